[sv/brs_pkg.sv]
`default_nettype none

package brs_pkg;

  // Fields of one received packet item.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_sec;
    logic [31:0] change_id;
    logic [31:0] change_id_orig;
    logic [7:0]  bitmap_byte;
    logic [6:0]  byte_index;
    logic        last_chunk;
    logic [31:0] oldest_new_id;
    logic [9:0]  range_start;
    logic [9:0]  range_end;
    logic [31:0] delay_ms;
    logic [9:0]  sector;
  } brs_in_t;

  // Fields of one result item.
  typedef struct packed {
    logic        ignored;
    logic        write_request;
    logic [9:0]  write_block;
    logic [31:0] write_id;
    logic [1:0]  sync_mode;
    logic        all_current;
    logic        newer_block_seen;
    logic        id_mismatch;
  } brs_out_t;

  // Packet kinds.
  localparam logic [1:0] MODE_BITMAP  = 2'd0;
  localparam logic [1:0] MODE_OLDER   = 2'd1;
  localparam logic [1:0] MODE_CHANGE  = 2'd2;
  localparam logic [1:0] MODE_CAT_PTR = 2'd3;

  // Sync modes.
  localparam logic [1:0] SYNC_WAIT_PTR  = 2'd0;
  localparam logic [1:0] SYNC_WAIT_CAT  = 2'd1;
  localparam logic [1:0] SYNC_WAIT_OLD  = 2'd2;
  localparam logic [1:0] SYNC_WAIT_DATA = 2'd3;

  localparam logic [31:0] ID_MAX      = 32'hFFFF_FFFF;
  localparam logic [31:0] MS_PER_SEC  = 32'd1000;
  // ceil(2^38 / 1000): quotient by 1000 is a multiply and a shift by 38.
  localparam logic [31:0] RECIP_1000  = 32'd274877907;
  localparam int          RECIP_SHIFT = 38;

endpackage

`default_nettype wire

[sv/block_sync_receiver.sv]
// Channel  | Direction | Payload          | Handshake
// in       | input     | brs_in_t         | in_valid_i / in_stall_o
// out      | output    | brs_out_t        | out_valid_o / out_stall_i
//
// Every accepted transaction yields exactly one result transaction.
// An ignored item goes from dispatch straight to its result; a catalog pointer
// may pass through the sleep state first. An older marker runs at most a
// minimum scan plus range walk over the block id memory, one read per cycle on
// its single read port. Bitmap and change packets may update the table and
// then scan it. After reset the block id memory is cleared, one entry a cycle,
// with in_stall_o held high.
// A finished result waits in an output register, so a stalled output still
// lets the next input transaction in; only that item's result then waits.

`default_nettype none

module block_sync_receiver
  import brs_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire brs_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output brs_out_t      out_data_o
);

  // Address width of the table, counter width that holds NUM_BLOCKS itself,
  // and a compare width wide enough for both the counters and the 10-bit fields.
  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int XW = (CW > 10) ? CW : 11;
  localparam logic [XW-1:0] NB = XW'(NUM_BLOCKS);

  // Sequencer states.
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_BM_RD = 4'd3;
  localparam logic [3:0] S_BM_WR = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_MIN   = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_CH_RD = 4'd8;
  localparam logic [3:0] S_CH_WR = 4'd9;
  localparam logic [3:0] S_SLEEP = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]    st_q, st_d;
  logic [1:0]    sync_q, sync_d;
  logic [31:0]   sleep_q, sleep_d;
  logic [31:0]   cur_q, cur_d;
  logic          all_q, all_d;
  brs_in_t       in_q, in_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [2:0]    k_q, k_d;
  logic          rvld_q, rvld_d;
  logic [31:0]   acc_q, acc_d;
  logic          flag_q, flag_d;
  logic          ign_q, ign_d;
  logic          wreq_q, wreq_d;
  logic          newer_q, newer_d;
  logic          mism_q, mism_d;
  logic [9:0]    wblk_q, wblk_d;
  logic [31:0]   wid_q, wid_d;
  logic          out_vld_q, out_vld_d;
  brs_out_t      out_q, out_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [31:0]   delay_sec;
  logic [9:0]    bm_blk;
  logic          bm_in_range;
  logic          sec_in_range;
  logic          issue;
  logic          scan_state;
  logic [AW-1:0] walk_start;

  brs_ram #(
    .WIDTH (32),
    .DEPTH (NUM_BLOCKS)
  ) u_ids (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  brs_div1000 u_div (
    .clk_i (clk_i),
    .ms_i  (in_q.delay_ms),
    .sec_o (delay_sec)
  );

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign bm_blk       = {in_q.byte_index, k_q};
  assign bm_in_range  = XW'(bm_blk) < NB;
  assign sec_in_range = XW'(in_q.sector) < NB;
  assign walk_start   = (XW'(in_q.range_start) >= NB) ? '0 : AW'(in_q.range_start);
  assign scan_state   = (st_q == S_SCAN) || (st_q == S_MIN) || (st_q == S_WALK);

  // A scan issues one table read per cycle; the range walk also stops at its end block.
  always_comb begin
    issue = scan_state && (XW'(cnt_q) < NB);
    if (st_q == S_WALK && XW'(pos_q) == XW'(in_q.range_end)) begin
      issue = 1'b0;
    end
  end

  always_comb begin
    unique case (st_q)
      S_BM_RD: raddr = AW'(bm_blk);
      S_CH_RD: raddr = AW'(in_q.sector);
      S_WALK:  raddr = pos_q;
      default: raddr = cnt_q[AW-1:0];
    endcase
  end

  always_comb begin
    st_d      = st_q;
    sync_d    = sync_q;
    sleep_d   = sleep_q;
    cur_d     = cur_q;
    all_d     = all_q;
    in_d      = in_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    k_d       = k_q;
    rvld_d    = 1'b0;
    acc_d     = acc_q;
    flag_d    = flag_q;
    ign_d     = ign_q;
    wreq_d    = wreq_q;
    newer_d   = newer_q;
    mism_d    = mism_q;
    wblk_d    = wblk_q;
    wid_d     = wid_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    we        = 1'b0;
    waddr     = cnt_q[AW-1:0];
    wdata     = '0;

    // Shared scan datapath: counter, walk position and per-entry compare.
    if (issue) begin
      cnt_d = cnt_q + CW'(1);
      pos_d = (pos_q == AW'(NUM_BLOCKS - 1)) ? '0 : pos_q + AW'(1);
    end
    if (scan_state) begin
      rvld_d = issue;
    end
    if (rvld_q) begin
      unique case (st_q)
        S_SCAN:  flag_d = flag_q && (rdata >= cur_q);
        S_MIN:   acc_d  = (rdata < acc_q) ? rdata : acc_q;
        S_WALK:  flag_d = flag_q || (rdata != cur_q);
        default: ;
      endcase
    end

    unique case (st_q)
      S_CLR: begin
        we    = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NUM_BLOCKS - 1)) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          st_d = S_DISP;
        end
      end
      S_DISP: begin
        ign_d   = 1'b0;
        wreq_d  = 1'b0;
        newer_d = 1'b0;
        mism_d  = 1'b0;
        wblk_d  = '0;
        wid_d   = '0;
        cnt_d   = '0;
        flag_d  = 1'b1;
        if (in_q.now_sec < sleep_q) begin
          ign_d = 1'b1;
          st_d  = S_DONE;
        end else begin
          unique case (in_q.mode)
            MODE_BITMAP: begin
              cur_d = in_q.change_id;
              k_d   = '0;
              st_d  = S_BM_RD;
            end
            MODE_OLDER: begin
              acc_d = ID_MAX;
              st_d  = (sync_q == SYNC_WAIT_OLD || sync_q == SYNC_WAIT_DATA) ? S_MIN : S_DONE;
            end
            MODE_CHANGE: begin
              if (sync_q == SYNC_WAIT_PTR) begin
                st_d = S_DONE;
              end else begin
                if (in_q.change_id != cur_q) begin
                  mism_d = 1'b1;
                  sync_d = SYNC_WAIT_PTR;
                end
                st_d = sec_in_range ? S_CH_RD : S_SCAN;
              end
            end
            default: begin
              if (sync_q == SYNC_WAIT_PTR) begin
                sync_d = SYNC_WAIT_CAT;
                st_d   = S_SLEEP;
              end else begin
                st_d = S_DONE;
              end
            end
          endcase
        end
      end
      S_BM_RD: begin
        st_d = S_BM_WR;
      end
      S_BM_WR: begin
        if (in_q.bitmap_byte[k_q] && bm_in_range && rdata >= in_q.change_id_orig) begin
          we    = 1'b1;
          waddr = AW'(bm_blk);
          wdata = cur_q;
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd7) begin
          cnt_d  = '0;
          flag_d = 1'b1;
          st_d   = S_SCAN;
        end else begin
          st_d = S_BM_RD;
        end
      end
      S_CH_RD: begin
        st_d = S_CH_WR;
      end
      S_CH_WR: begin
        if (rdata > cur_q) begin
          newer_d = 1'b1;
        end else if (rdata != cur_q) begin
          we     = 1'b1;
          waddr  = AW'(in_q.sector);
          wdata  = in_q.change_id;
          wreq_d = 1'b1;
          wblk_d = in_q.sector;
          wid_d  = in_q.change_id;
        end
        cnt_d  = '0;
        flag_d = 1'b1;
        st_d   = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !rvld_q) begin
          all_d = flag_q;
          if (in_q.mode == MODE_BITMAP) begin
            if (in_q.last_chunk) begin
              sync_d = flag_q ? SYNC_WAIT_PTR : SYNC_WAIT_DATA;
            end
          end else if (flag_q) begin
            sync_d = SYNC_WAIT_PTR;
          end
          st_d = S_DONE;
        end
      end
      S_MIN: begin
        if (!issue && !rvld_q) begin
          if (acc_q > in_q.oldest_new_id) begin
            sync_d = SYNC_WAIT_DATA;
            st_d   = S_DONE;
          end else begin
            cnt_d  = '0;
            pos_d  = walk_start;
            flag_d = 1'b0;
            st_d   = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (!issue && !rvld_q) begin
          if (flag_q) begin
            sync_d = SYNC_WAIT_DATA;
            st_d   = S_SLEEP;
          end else begin
            sync_d = SYNC_WAIT_PTR;
            st_d   = S_DONE;
          end
        end
      end
      S_SLEEP: begin
        sleep_d = in_q.now_sec + delay_sec - 32'd1;
        st_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d              = 1'b1;
          out_d.ignored          = ign_q;
          out_d.write_request    = wreq_q;
          out_d.write_block      = wblk_q;
          out_d.write_id         = wid_q;
          out_d.sync_mode        = sync_q;
          out_d.all_current      = all_q;
          out_d.newer_block_seen = newer_q;
          out_d.id_mismatch      = mism_q;
          st_d                   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_CLR;
      sync_q    <= SYNC_WAIT_PTR;
      sleep_q   <= '0;
      cur_q     <= '0;
      all_q     <= 1'b1;
      cnt_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      sync_q    <= sync_d;
      sleep_q   <= sleep_d;
      cur_q     <= cur_d;
      all_q     <= all_d;
      cnt_q     <= cnt_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    pos_q   <= pos_d;
    k_q     <= k_d;
    acc_q   <= acc_d;
    flag_q  <= flag_d;
    ign_q   <= ign_d;
    wreq_q  <= wreq_d;
    newer_q <= newer_d;
    mism_q  <= mism_d;
    wblk_q  <= wblk_d;
    wid_q   <= wid_d;
    out_q   <= out_d;
  end

endmodule

`default_nettype wire

[sv/brs_ram.sv]
`default_nettype none

module brs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/brs_div1000.sv]
`default_nettype none

module brs_div1000
  import brs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [31:0] ms_i,
  output logic      [31:0] sec_o
);

  logic [63:0] prod_q;
  logic [31:0] ms_q;
  logic [25:0] quot;
  logic [35:0] back;

  // The product is registered; the correction multiply follows next cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= ms_i * RECIP_1000;
    ms_q   <= ms_i;
  end

  always_comb begin
    quot = prod_q[63:RECIP_SHIFT];
    back = quot * MS_PER_SEC[9:0];
    if (back > {4'd0, ms_q}) begin
      sec_o = 32'(quot - 26'd1);
    end else begin
      sec_o = 32'(quot);
    end
  end

endmodule

`default_nettype wire

[sv/brs_checker.sv]
`default_nettype none

module brs_checker
  import brs_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire brs_out_t out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One item at a time: after a transaction the input stalls.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  a_ign_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ignored |-> !out_data_o.write_request &&
      !out_data_o.id_mismatch && !out_data_o.newer_block_seen)
    else $error("ignored item has effects");

  a_no_req_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_request |->
      out_data_o.write_block == 10'd0 && out_data_o.write_id == 32'd0)
    else $error("write fields set without request");

  a_newer_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.newer_block_seen |-> !out_data_o.write_request)
    else $error("write requested for newer block");

endmodule

bind block_sync_receiver brs_checker u_brs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/block_sync_receiver_tb.sv]
`default_nettype none

// Scoreboard: keeps a private copy of the receiver state, works out the
// result of every accepted packet item and checks the results in order.
class sync_scoreboard;
  logic [1:0]  sync_state;
  logic [31:0] sleep_until;
  logic [31:0] current_id;
  logic [31:0] ids [1024];
  brs_pkg::brs_out_t pending [$];
  int errors;
  int results;

  function new();
    sync_state  = brs_pkg::SYNC_WAIT_PTR;
    sleep_until = '0;
    current_id  = '0;
    foreach (ids[b]) ids[b] = '0;
    errors  = 0;
    results = 0;
  endfunction

  function bit table_is_current();
    foreach (ids[b]) if (ids[b] < current_id) return 1'b0;
    return 1'b1;
  endfunction

  function logic [31:0] oldest_id();
    logic [31:0] m;
    m = brs_pkg::ID_MAX;
    foreach (ids[b]) if (ids[b] < m) m = ids[b];
    return m;
  endfunction

  // Walks the wrapping block range and tells whether any block is stale.
  function bit range_is_stale(logic [9:0] first, logic [9:0] stop);
    logic [9:0] pos;
    pos = first;
    for (int n = 0; n < 1024 && pos != stop; n++) begin
      if (ids[pos] != current_id) return 1'b1;
      pos = pos + 10'd1;
    end
    return 1'b0;
  endfunction

  function void start_sleep(logic [31:0] now, logic [31:0] delay);
    sleep_until = now + delay / brs_pkg::MS_PER_SEC - 32'd1;
  endfunction

  // Applies one accepted packet item and queues the result it must produce.
  function void note_packet(brs_pkg::brs_in_t p);
    brs_pkg::brs_out_t r;
    logic [9:0] blk;
    r = '0;
    if (p.now_sec < sleep_until) begin
      r.ignored = 1'b1;
    end else begin
      case (p.mode)
        brs_pkg::MODE_BITMAP: begin
          current_id = p.change_id;
          for (int k = 0; k < 8; k++) begin
            blk = {p.byte_index, 3'(k)};
            if (p.bitmap_byte[k] && ids[blk] >= p.change_id_orig) ids[blk] = current_id;
          end
          if (p.last_chunk)
            sync_state = table_is_current() ? brs_pkg::SYNC_WAIT_PTR : brs_pkg::SYNC_WAIT_DATA;
        end
        brs_pkg::MODE_OLDER: begin
          if (sync_state == brs_pkg::SYNC_WAIT_OLD || sync_state == brs_pkg::SYNC_WAIT_DATA) begin
            if (oldest_id() > p.oldest_new_id) begin
              sync_state = brs_pkg::SYNC_WAIT_DATA;
            end else if (range_is_stale(p.range_start, p.range_end)) begin
              start_sleep(p.now_sec, p.delay_ms);
              sync_state = brs_pkg::SYNC_WAIT_DATA;
            end else begin
              sync_state = brs_pkg::SYNC_WAIT_PTR;
            end
          end
        end
        brs_pkg::MODE_CHANGE: begin
          if (sync_state != brs_pkg::SYNC_WAIT_PTR) begin
            if (p.change_id != current_id) begin
              r.id_mismatch = 1'b1;
              sync_state = brs_pkg::SYNC_WAIT_PTR;
            end
            if (ids[p.sector] > current_id) begin
              r.newer_block_seen = 1'b1;
            end else if (ids[p.sector] != current_id) begin
              r.write_request = 1'b1;
              r.write_block   = p.sector;
              r.write_id      = p.change_id;
              ids[p.sector]   = p.change_id;
            end
            if (table_is_current()) sync_state = brs_pkg::SYNC_WAIT_PTR;
          end
        end
        default: begin
          if (sync_state == brs_pkg::SYNC_WAIT_PTR) begin
            sync_state = brs_pkg::SYNC_WAIT_CAT;
            start_sleep(p.now_sec, p.delay_ms);
          end
        end
      endcase
    end
    r.sync_mode   = sync_state;
    r.all_current = table_is_current();
    pending.push_back(r);
  endfunction

  function void check_result(brs_pkg::brs_out_t got);
    brs_pkg::brs_out_t want;
    results++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
      errors++;
    end
  endfunction
endclass

module block_sync_receiver_tb;
  import brs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NUM_ITEMS   = 290;
  localparam int  CYCLE_LIMIT = 3_000_000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  brs_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  brs_out_t out_data_o;

  sync_scoreboard sb = new();
  int sent;
  int mode_count [4];
  int cycles;
  int burst_left;

  block_sync_receiver uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // Watchdog. The slowest item is an older marker of roughly two table scans,
  // so the limit covers every item at that worst case on top of the clear pass.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: every transaction is handed to the scoreboard. The stall
  // pattern steps through none, light, heavy and a regular on-off stall.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    case (cycles[9:8])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= cycles[4];
    endcase
  end

  // Sends one packet item and notes it once the transaction is accepted.
  // Valid stays high afterwards; the gap logic lowers it between bursts.
  task automatic send_packet(input brs_in_t p);
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_packet(p);
    sent++;
    mode_count[p.mode]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  endtask

  // A packet with every field random over its full range.
  function automatic brs_in_t noise_packet();
    brs_in_t p;
    p.mode           = 2'($urandom);
    p.now_sec        = $urandom;
    p.change_id      = $urandom;
    p.change_id_orig = $urandom;
    p.bitmap_byte    = 8'($urandom);
    p.byte_index     = 7'($urandom);
    p.last_chunk     = 1'($urandom);
    p.oldest_new_id  = $urandom;
    p.range_start    = 10'($urandom);
    p.range_end      = 10'($urandom);
    p.delay_ms       = $urandom;
    p.sector         = 10'($urandom);
    return p;
  endfunction

  // An awake time: at the sleep deadline or a little after it, unless it
  // would wrap.
  function automatic logic [31:0] awake_time();
    logic [31:0] t;
    t = sb.sleep_until + 32'($urandom_range(0, 3));
    return (t < sb.sleep_until) ? sb.sleep_until : t;
  endfunction

  // Ids near the current one so that the comparisons go both ways.
  function automatic logic [31:0] near_id();
    return sb.current_id + 32'($urandom_range(0, 4)) - 32'd2;
  endfunction

  function automatic brs_in_t packet_of(logic [1:0] kind);
    brs_in_t p;
    p = noise_packet();
    p.mode     = kind;
    p.now_sec  = awake_time();
    p.delay_ms = $urandom_range(0, 4000);
    return p;
  endfunction

  // One well-formed round: catalog pointer, a bitmap run, then changes and
  // older markers.
  task automatic sync_round();
    brs_in_t p;
    int chunks;
    p = packet_of(MODE_CAT_PTR);
    send_packet(p);
    chunks = $urandom_range(1, 4);
    for (int c = 0; c < chunks; c++) begin
      p = packet_of(MODE_BITMAP);
      p.change_id      = ($urandom_range(0, 2) == 0) ? sb.current_id
                                                    : sb.current_id + 32'($urandom_range(1, 3));
      p.change_id_orig = sb.current_id - 32'($urandom_range(0, 2));
      p.last_chunk     = (c == chunks - 1);
      send_packet(p);
    end
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 2) != 0) begin
        p = packet_of(MODE_CHANGE);
        p.change_id = ($urandom_range(0, 7) == 0) ? near_id() : sb.current_id;
      end else begin
        p = packet_of(MODE_OLDER);
        p.oldest_new_id = sb.oldest_id() + 32'($urandom_range(0, 2)) - 32'd1;
        p.range_end     = p.range_start + 10'($urandom_range(0, 20));
      end
      send_packet(p);
    end
  endtask

  initial begin
    brs_in_t p;
    cycles = 0;
    sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Change and older marker are ignored in the wait for a
    // catalog pointer.
    p = packet_of(MODE_CHANGE);   p.now_sec = '0; send_packet(p);
    p = packet_of(MODE_OLDER);    p.now_sec = '0; send_packet(p);
    // A zero delay at time zero wraps the deadline to the top of the range:
    // everything is dropped until the time itself reaches the top.
    p = packet_of(MODE_CAT_PTR);  p.now_sec = '0; p.delay_ms = '0; send_packet(p);
    p = packet_of(MODE_BITMAP);   p.now_sec = 32'hFFFF_FFFE; send_packet(p);
    p = packet_of(MODE_BITMAP);
    p.now_sec = ID_MAX; p.change_id = 32'd5; p.change_id_orig = '0;
    p.byte_index = 7'h7F; p.bitmap_byte = 8'hFF; p.last_chunk = 1'b1;
    send_packet(p);
    // Change packets: highest sector with a matching id, then a stale block that is written.
    p = packet_of(MODE_CHANGE); p.now_sec = ID_MAX; p.change_id = 32'd5; p.sector = 10'h3FF;
    send_packet(p);
    p = packet_of(MODE_CHANGE); p.now_sec = ID_MAX; p.change_id = 32'd5; p.sector = 10'd0;
    send_packet(p);
    // Older markers: random range, empty range, wrapping range.
    p = packet_of(MODE_BITMAP);
    p.now_sec = ID_MAX; p.change_id = 32'd6; p.change_id_orig = 32'd5;
    p.byte_index = 7'h7F; p.bitmap_byte = 8'h01; p.last_chunk = 1'b1;
    send_packet(p);
    p = packet_of(MODE_OLDER); p.now_sec = ID_MAX; p.oldest_new_id = '0; send_packet(p);
    p = packet_of(MODE_OLDER); p.now_sec = ID_MAX; p.oldest_new_id = ID_MAX;
    p.range_start = 10'd5; p.range_end = 10'd5; send_packet(p);
    p = packet_of(MODE_BITMAP);
    p.now_sec = ID_MAX; p.change_id = 32'd7; p.change_id_orig = ID_MAX;
    p.bitmap_byte = 8'h00; p.last_chunk = 1'b1; send_packet(p);
    p = packet_of(MODE_OLDER); p.now_sec = ID_MAX; p.oldest_new_id = ID_MAX;
    p.range_start = 10'h3FE; p.range_end = 10'd3; p.delay_ms = ID_MAX; send_packet(p);
    p = packet_of(MODE_CHANGE); p.now_sec = ID_MAX; p.change_id = ID_MAX; p.sector = 10'd9;
    send_packet(p);
    p = packet_of(MODE_CAT_PTR); p.now_sec = ID_MAX; p.delay_ms = ID_MAX; send_packet(p);
    p = noise_packet(); p.now_sec = '0; send_packet(p);

    // Random part: mostly well-formed rounds, the rest full-range noise and
    // items sent before the deadline.
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        sync_round();
      end else begin
        p = noise_packet();
        if ($urandom_range(0, 1) == 0) p.now_sec = awake_time();
        send_packet(p);
      end
    end
    in_valid_i <= 1'b0;

    wait (sb.pending.size() == 0);
    repeat (2100) @(posedge clk_i);
    $display("Sent %0d packet items (bitmap %0d, older %0d, change %0d, catalog %0d).",
             sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("Checked %0d results, %0d mismatches.", sb.results, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

`default_nettype wire
